FILE: rtl/bupq_pkg.sv
package bupq_pkg;

  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  // count must hold RING_DEPTH + 1 while an attach overflows a full ring
  localparam int CNT_W      = $clog2(RING_DEPTH + 2);

  localparam int KIND_W   = 2;
  localparam int WORD_W   = 64;
  localparam int HEIGHT_W = 32;
  localparam int SIZE_W   = 7;

  typedef enum logic [KIND_W-1:0] {
    K_ATTACH = 2'd0,
    K_DETACH = 2'd1,
    K_RESIZE = 2'd2,
    K_RESET  = 2'd3
  } in_kind_t;

  typedef enum logic [KIND_W-1:0] {
    R_RELEASE   = 2'd0,
    R_PRUNE     = 2'd1,
    R_EMPTY     = 2'd2,
    R_BADHEIGHT = 2'd3
  } out_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIRST,
    ST_EMPTY,
    ST_CHECK,
    ST_READ,
    ST_REL,
    ST_RELNEW
  } state_t;

endpackage

FILE: rtl/bupq_req_if.sv
interface bupq_req_if;
  logic                            valid;
  logic                            ready;
  logic [bupq_pkg::KIND_W-1:0]     kind;
  logic [bupq_pkg::WORD_W-1:0]     in_hash_w0;
  logic [bupq_pkg::WORD_W-1:0]     in_hash_w1;
  logic [bupq_pkg::WORD_W-1:0]     in_hash_w2;
  logic [bupq_pkg::WORD_W-1:0]     in_hash_w3;
  logic [bupq_pkg::HEIGHT_W-1:0]   height;
  logic [bupq_pkg::SIZE_W-1:0]     new_size;

  modport source (
    output valid, kind, in_hash_w0, in_hash_w1, in_hash_w2, in_hash_w3, height, new_size,
    input  ready
  );
  modport sink (
    input  valid, kind, in_hash_w0, in_hash_w1, in_hash_w2, in_hash_w3, height, new_size,
    output ready
  );
endinterface

FILE: rtl/bupq_rsp_if.sv
interface bupq_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [bupq_pkg::KIND_W-1:0]     out_kind;
  logic [bupq_pkg::WORD_W-1:0]     rel_hash_w0;
  logic [bupq_pkg::WORD_W-1:0]     rel_hash_w1;
  logic [bupq_pkg::WORD_W-1:0]     rel_hash_w2;
  logic [bupq_pkg::WORD_W-1:0]     rel_hash_w3;
  logic [bupq_pkg::HEIGHT_W-1:0]   below_height;
  logic                            last;

  modport source (
    output valid, out_kind, rel_hash_w0, rel_hash_w1, rel_hash_w2, rel_hash_w3,
           below_height, last,
    input  ready
  );
  modport sink (
    input  valid, out_kind, rel_hash_w0, rel_hash_w1, rel_hash_w2, rel_hash_w3,
           below_height, last,
    output ready
  );
endinterface

FILE: rtl/bounded_undo_pruning_queue.sv
// Channel  Dir  Word                                              Accepted when
// req      in   kind, in_hash_w0..w3, height, new_size            req.valid && req.ready
// rsp      out  out_kind, rel_hash_w0..w3, below_height, last     rsp.valid && rsp.ready
//
// States: detach, reset: decode; quiet attach/resize: decode, check; empty detach:
//   decode, empty; first fill: emit; from ring: test, read, emit; new id: test, emit.
// Reset: rst (synchronous) empties the ring, sets desired size to the ring depth and
//   clears the first-fill flag; ring contents are not cleared and need no clearing pass.
// Stalls: results sit in one output register; the sequencer holds in an emit state
//   while that register is full and not taken. req.ready is high only when idle.
module bounded_undo_pruning_queue (
  input  logic         clk,
  input  logic         rst,
  bupq_req_if.sink     req,
  bupq_rsp_if.source   rsp
);

  localparam int IDX_W  = bupq_pkg::IDX_W;
  localparam int CNT_W  = bupq_pkg::CNT_W;
  localparam int WORD_W = bupq_pkg::WORD_W;
  localparam int HGT_W  = bupq_pkg::HEIGHT_W;

  // ring storage, one array per identifier word
  logic [WORD_W-1:0] ring_w0 [bupq_pkg::RING_DEPTH];
  logic [WORD_W-1:0] ring_w1 [bupq_pkg::RING_DEPTH];
  logic [WORD_W-1:0] ring_w2 [bupq_pkg::RING_DEPTH];
  logic [WORD_W-1:0] ring_w3 [bupq_pkg::RING_DEPTH];
  logic [WORD_W-1:0] rd_w0, rd_w1, rd_w2, rd_w3;

  // control state
  bupq_pkg::state_t  state, state_next;
  logic [IDX_W-1:0]  front_index;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  desired_size;
  logic              initial_done;
  logic [CNT_W-1:0]  work;        // virtual count being brought down to desired_size
  logic              consumed;    // new identifier released instead of stored

  // latched request
  bupq_pkg::in_kind_t        kind_q;
  logic [WORD_W-1:0]         hash_q0, hash_q1, hash_q2, hash_q3;
  logic [HGT_W-1:0]          height_q;
  logic [bupq_pkg::SIZE_W-1:0] size_q;

  // first-fill decision, registered in DECODE
  logic              ff_bad;
  logic [HGT_W-1:0]  below_q;

  // output register
  logic                      out_valid;
  bupq_pkg::out_kind_t       out_kind_q;
  logic [WORD_W-1:0]         out_w0, out_w1, out_w2, out_w3;
  logic [HGT_W-1:0]          out_below;
  logic                      out_last;

  // decode arithmetic
  logic [CNT_W-1:0]  vcount;
  logic [HGT_W:0]    h_plus1;
  logic [HGT_W:0]    vcount_ext;
  logic              dec_bad, dec_prune, dec_first;
  logic [CNT_W-1:0]  size_sat;

  // shared loop comparator and its successor test
  logic              more;        // work > desired_size
  logic              last_rel;    // this release ends the loop
  logic [CNT_W:0]    desired_p1;

  logic              slot_free;
  logic [IDX_W:0]    back_sum;
  logic [IDX_W-1:0]  back_index;
  logic [IDX_W-1:0]  front_inc;

  // emit controls
  logic                  emit;
  bupq_pkg::out_kind_t   emit_kind;
  logic                  emit_last;
  logic                  do_store;

  assign vcount     = entry_count + CNT_W'(1);
  assign h_plus1    = {1'b0, height_q} + (HGT_W+1)'(1);
  assign vcount_ext = (HGT_W+1)'(vcount);
  assign dec_bad    = h_plus1 < vcount_ext;
  assign dec_prune  = h_plus1 > vcount_ext;
  assign dec_first  = !initial_done && (vcount >= desired_size);
  assign size_sat   = (size_q > bupq_pkg::SIZE_W'(bupq_pkg::RING_DEPTH))
                      ? CNT_W'(bupq_pkg::RING_DEPTH) : CNT_W'(size_q);

  assign more       = work > desired_size;
  assign desired_p1 = {1'b0, desired_size} + (CNT_W+1)'(1);
  assign last_rel   = {1'b0, work} <= desired_p1;

  assign slot_free  = !out_valid || rsp.ready;

  // back slot = (front + count) mod depth; count < depth whenever a store happens
  assign back_sum   = {1'b0, front_index} + (IDX_W+1)'(entry_count);
  assign back_index = (back_sum >= (IDX_W+1)'(bupq_pkg::RING_DEPTH))
                      ? IDX_W'(back_sum - (IDX_W+1)'(bupq_pkg::RING_DEPTH))
                      : IDX_W'(back_sum);
  assign front_inc  = (front_index == IDX_W'(bupq_pkg::RING_DEPTH - 1))
                      ? '0 : front_index + IDX_W'(1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bupq_pkg::ST_IDLE: begin
        if (req.valid) state_next = bupq_pkg::ST_DECODE;
      end
      bupq_pkg::ST_DECODE: begin
        unique case (kind_q)
          bupq_pkg::K_ATTACH: begin
            state_next = (dec_first && (dec_bad || dec_prune))
                         ? bupq_pkg::ST_FIRST : bupq_pkg::ST_CHECK;
          end
          bupq_pkg::K_DETACH: begin
            state_next = (entry_count == '0) ? bupq_pkg::ST_EMPTY : bupq_pkg::ST_IDLE;
          end
          bupq_pkg::K_RESIZE: state_next = bupq_pkg::ST_CHECK;
          bupq_pkg::K_RESET:  state_next = bupq_pkg::ST_IDLE;
          default:            state_next = bupq_pkg::ST_IDLE;
        endcase
      end
      bupq_pkg::ST_FIRST: begin
        if (slot_free) state_next = bupq_pkg::ST_CHECK;
      end
      bupq_pkg::ST_EMPTY: begin
        if (slot_free) state_next = bupq_pkg::ST_IDLE;
      end
      bupq_pkg::ST_CHECK: begin
        if (more) begin
          state_next = (entry_count != '0) ? bupq_pkg::ST_READ : bupq_pkg::ST_RELNEW;
        end else begin
          state_next = bupq_pkg::ST_IDLE;
        end
      end
      bupq_pkg::ST_READ: state_next = bupq_pkg::ST_REL;
      bupq_pkg::ST_REL: begin
        if (slot_free) state_next = bupq_pkg::ST_CHECK;
      end
      bupq_pkg::ST_RELNEW: begin
        if (slot_free) state_next = bupq_pkg::ST_CHECK;
      end
      default: state_next = bupq_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready = 1'b0;
    emit      = 1'b0;
    emit_kind = bupq_pkg::R_RELEASE;
    emit_last = 1'b0;
    do_store  = 1'b0;
    unique case (state)
      bupq_pkg::ST_IDLE: req.ready = 1'b1;
      bupq_pkg::ST_FIRST: begin
        emit      = slot_free;
        emit_kind = ff_bad ? bupq_pkg::R_BADHEIGHT : bupq_pkg::R_PRUNE;
        emit_last = !more;
      end
      bupq_pkg::ST_EMPTY: begin
        emit      = slot_free;
        emit_kind = bupq_pkg::R_EMPTY;
        emit_last = 1'b1;
      end
      bupq_pkg::ST_CHECK: begin
        do_store = !more && (kind_q == bupq_pkg::K_ATTACH) && !consumed;
      end
      bupq_pkg::ST_REL, bupq_pkg::ST_RELNEW: begin
        emit      = slot_free;
        emit_kind = bupq_pkg::R_RELEASE;
        emit_last = last_rel;
      end
      bupq_pkg::ST_DECODE, bupq_pkg::ST_READ: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bupq_pkg::ST_IDLE;
      front_index  <= '0;
      entry_count  <= '0;
      desired_size <= CNT_W'(bupq_pkg::RING_DEPTH);
      initial_done <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bupq_pkg::ST_DECODE) begin
        unique case (kind_q)
          bupq_pkg::K_ATTACH: begin
            if (dec_first) initial_done <= 1'b1;
          end
          bupq_pkg::K_DETACH: begin
            if (entry_count != '0) entry_count <= entry_count - CNT_W'(1);
          end
          bupq_pkg::K_RESIZE: desired_size <= size_sat;
          bupq_pkg::K_RESET: begin
            front_index  <= '0;
            entry_count  <= '0;
            initial_done <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (state == bupq_pkg::ST_REL && slot_free) begin
        front_index <= front_inc;
        entry_count <= entry_count - CNT_W'(1);
      end
      if (do_store) entry_count <= entry_count + CNT_W'(1);
      if (emit) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      kind_q   <= bupq_pkg::in_kind_t'(req.kind);
      hash_q0  <= req.in_hash_w0;
      hash_q1  <= req.in_hash_w1;
      hash_q2  <= req.in_hash_w2;
      hash_q3  <= req.in_hash_w3;
      height_q <= req.height;
      size_q   <= req.new_size;
    end
    if (state == bupq_pkg::ST_DECODE) begin
      ff_bad   <= dec_bad;
      below_q  <= height_q - HGT_W'(vcount);
      consumed <= 1'b0;
      work     <= (kind_q == bupq_pkg::K_ATTACH) ? vcount : entry_count;
    end
    if ((state == bupq_pkg::ST_REL || state == bupq_pkg::ST_RELNEW) && slot_free) begin
      work <= work - CNT_W'(1);
    end
    if (state == bupq_pkg::ST_RELNEW && slot_free) consumed <= 1'b1;
    if (emit) begin
      out_kind_q <= emit_kind;
      out_last   <= emit_last;
      out_below  <= (emit_kind == bupq_pkg::R_PRUNE) ? below_q : '0;
      unique case (state)
        bupq_pkg::ST_REL: begin
          out_w0 <= rd_w0;
          out_w1 <= rd_w1;
          out_w2 <= rd_w2;
          out_w3 <= rd_w3;
        end
        bupq_pkg::ST_RELNEW: begin
          out_w0 <= hash_q0;
          out_w1 <= hash_q1;
          out_w2 <= hash_q2;
          out_w3 <= hash_q3;
        end
        default: begin
          out_w0 <= '0;
          out_w1 <= '0;
          out_w2 <= '0;
          out_w3 <= '0;
        end
      endcase
    end
  end

  // ring: one write port at the back, one registered read port at the front
  always_ff @(posedge clk) begin
    if (do_store) begin
      ring_w0[back_index] <= hash_q0;
      ring_w1[back_index] <= hash_q1;
      ring_w2[back_index] <= hash_q2;
      ring_w3[back_index] <= hash_q3;
    end
    rd_w0 <= ring_w0[front_index];
    rd_w1 <= ring_w1[front_index];
    rd_w2 <= ring_w2[front_index];
    rd_w3 <= ring_w3[front_index];
  end

  assign rsp.valid        = out_valid;
  assign rsp.out_kind     = out_kind_q;
  assign rsp.rel_hash_w0  = out_w0;
  assign rsp.rel_hash_w1  = out_w1;
  assign rsp.rel_hash_w2  = out_w2;
  assign rsp.rel_hash_w3  = out_w3;
  assign rsp.below_height = out_below;
  assign rsp.last         = out_last;

endmodule
